// ----- sv/rct_pkg.sv -----
package rct_pkg;

  // Domain and node indexing
  localparam int POSITION_BITS = 16;
  localparam int NODE_W        = POSITION_BITS + 1;
  localparam int PTR_W         = POSITION_BITS + 2;
  localparam int LVL_W         = $clog2(POSITION_BITS + 1);
  localparam int RAM_DEPTH     = 2 ** POSITION_BITS;
  localparam logic [31:0] DOMAIN_SIZE = 32'(1) << POSITION_BITS;

  // Input field widths
  localparam int OP_W    = 2;
  localparam int START_W = 16;
  localparam int END_W   = 17;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // One tree node: covered flag and pending assignment flag
  typedef struct packed {
    logic cov;
    logic pend;
  } node_t;

  // One memory word: the two children of one parent
  typedef node_t [1:0] node_pair_t;

  // Command handed from the front end to the sequencer
  typedef struct packed {
    logic             known;
    logic             query;
    logic             value;
    logic             empty;
    logic [PTR_W-1:0] lo;
    logic [PTR_W-1:0] hi;
  } cmd_t;

  // Node memory request
  typedef struct packed {
    logic                     rd_en;
    logic [POSITION_BITS-1:0] rd_addr;
    logic                     wr_en;
    logic [POSITION_BITS-1:0] wr_addr;
    node_pair_t               wr_data;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_CHK,
    ST_PUSH_CLR,
    ST_LOOP_L,
    ST_LOOP_R,
    ST_LOOP_SH,
    ST_ND_RD,
    ST_ND_MOD,
    ST_RB_RDP,
    ST_RB_RDC,
    ST_RB_WR
  } state_t;

endpackage

// ----- sv/range_coverage_tracker_unit.sv -----
// An empty range or an unknown code starts no tree walk; an empty query strobes the next cycle.
// Throughput: one transaction at a time; busy is high until the tree walk ends.
// Reset: synchronous; an init state marks the root pending and uncovered, then idle.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module range_coverage_tracker_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rct_pkg::OP_W-1:0]     in_operation,
  input  logic [rct_pkg::START_W-1:0]  in_range_start,
  input  logic [rct_pkg::END_W-1:0]    in_range_end,
  output logic                         out_valid,
  output logic                         out_fully_covered
);
  import rct_pkg::*;

  logic              accept;
  logic [31:0]       s_w;
  logic [31:0]       e_w;
  logic [NODE_W-1:0] s_c;
  logic [NODE_W-1:0] e_c;
  cmd_t              cmd;
  mem_req_t          mem_req;
  node_pair_t        mem_rdata;

  assign accept = start && !busy;

  // Clip the range to the domain
  assign s_w = 32'(in_range_start);
  assign e_w = 32'(in_range_end);
  assign s_c = (s_w > DOMAIN_SIZE) ? DOMAIN_SIZE[NODE_W-1:0] : s_w[NODE_W-1:0];
  assign e_c = (e_w > DOMAIN_SIZE) ? DOMAIN_SIZE[NODE_W-1:0] : e_w[NODE_W-1:0];

  // Decode the transaction into leaf pointers
  always_comb begin
    cmd.known = (in_operation == OP_ADD) || (in_operation == OP_REMOVE) ||
                (in_operation == OP_QUERY);
    cmd.query = (in_operation == OP_QUERY);
    cmd.value = (in_operation == OP_ADD);
    cmd.empty = (s_c >= e_c);
    cmd.lo    = DOMAIN_SIZE[PTR_W-1:0] + PTR_W'(s_c);
    cmd.hi    = DOMAIN_SIZE[PTR_W-1:0] + PTR_W'(e_c);
  end

  rct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .out_cov   (out_fully_covered),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  rct_node_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Reset always leads into the init cycle
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // A nonempty known transaction starts a tree walk
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd.known && !cmd.empty |=> busy)
    else $error("tree walk did not start");

  // Updates and unknown codes never strobe a result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cmd.query |=> !out_valid)
    else $error("result strobed for a non-query");

  // An empty query answers zero in the next cycle
  a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd.query && cmd.empty |=> out_valid && !out_fully_covered)
    else $error("empty query answer wrong");

endmodule

// ----- sv/rct_node_ram.sv -----
module rct_node_ram (
  input  logic              clk,
  input  rct_pkg::mem_req_t req,
  output rct_pkg::node_pair_t rdata
);
  import rct_pkg::*;

  node_pair_t mem [RAM_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

// ----- sv/rct_ctrl.sv -----
module rct_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  rct_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                out_valid,
  output logic                out_cov,
  output rct_pkg::mem_req_t   mem_req,
  input  rct_pkg::node_pair_t mem_rdata
);
  import rct_pkg::*;

  state_t            state_r, state_nxt;
  logic              query_r, query_nxt;
  logic              value_r, value_nxt;
  logic [NODE_W-1:0] t0_r, t0_nxt;
  logic [NODE_W-1:0] t1_r, t1_nxt;
  logic [PTR_W-1:0]  lo_r, lo_nxt;
  logic [PTR_W-1:0]  hi_r, hi_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic              path_r, path_nxt;
  logic              side_r, side_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  node_pair_t        word_r, word_nxt;
  logic              acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_cov_r, out_cov_nxt;

  logic [NODE_W-1:0] tgt;
  logic [NODE_W-1:0] p_node;
  logic              push_last;
  logic              rb_last;
  logic              lvl_one;
  logic              lvl_top;
  logic [PTR_W-1:0]  hi_dec;
  node_pair_t        wdata;

  // Current path node and level bookkeeping
  assign tgt       = path_r ? t1_r : t0_r;
  assign p_node    = tgt >> lvl_r;
  assign lvl_one   = (lvl_r == LVL_W'(1));
  assign lvl_top   = (lvl_r == LVL_W'(POSITION_BITS));
  assign push_last = lvl_one && path_r;
  assign rb_last   = lvl_top && path_r;
  assign hi_dec    = hi_r - PTR_W'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:     state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (go && cmd.known && !cmd.empty) begin
          state_nxt = ST_PUSH_RD;
        end
      end
      ST_PUSH_RD:  state_nxt = ST_PUSH_CHK;
      ST_PUSH_CHK: begin
        if (mem_rdata[p_node[0]].pend) begin
          state_nxt = ST_PUSH_CLR;
        end else begin
          state_nxt = push_last ? ST_LOOP_L : ST_PUSH_RD;
        end
      end
      ST_PUSH_CLR: state_nxt = push_last ? ST_LOOP_L : ST_PUSH_RD;
      ST_LOOP_L: begin
        if (lo_r >= hi_r) begin
          state_nxt = query_r ? ST_IDLE : ST_RB_RDP;
        end else if (lo_r[0]) begin
          state_nxt = ST_ND_RD;
        end else begin
          state_nxt = ST_LOOP_R;
        end
      end
      ST_LOOP_R:   state_nxt = hi_r[0] ? ST_ND_RD : ST_LOOP_SH;
      ST_LOOP_SH:  state_nxt = ST_LOOP_L;
      ST_ND_RD:    state_nxt = ST_ND_MOD;
      ST_ND_MOD:   state_nxt = side_r ? ST_LOOP_SH : ST_LOOP_R;
      ST_RB_RDP:   state_nxt = ST_RB_RDC;
      ST_RB_RDC: begin
        if (mem_rdata[p_node[0]].pend) begin
          state_nxt = rb_last ? ST_IDLE : ST_RB_RDP;
        end else begin
          state_nxt = ST_RB_WR;
        end
      end
      ST_RB_WR:    state_nxt = rb_last ? ST_IDLE : ST_RB_RDP;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory requests
  always_comb begin
    query_nxt     = query_r;
    value_nxt     = value_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    lvl_nxt       = lvl_r;
    path_nxt      = path_r;
    side_nxt      = side_r;
    node_nxt      = node_r;
    word_nxt      = word_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_cov_nxt   = out_cov_r;
    wdata         = mem_rdata;
    mem_req       = '0;
    unique case (state_r)
      // Make the root pending and uncovered so nothing below is ever trusted
      ST_INIT: begin
        wdata[1]        = '{cov: 1'b0, pend: 1'b1};
        wdata[0]        = '{cov: 1'b0, pend: 1'b0};
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = '0;
        mem_req.wr_data = wdata;
      end
      // Capture a transaction
      ST_IDLE: begin
        if (go) begin
          query_nxt = cmd.query;
          value_nxt = cmd.value;
          t0_nxt    = cmd.lo[NODE_W-1:0];
          t1_nxt    = NODE_W'(cmd.hi - PTR_W'(1));
          lo_nxt    = cmd.lo;
          hi_nxt    = cmd.hi;
          lvl_nxt   = LVL_W'(POSITION_BITS);
          path_nxt  = 1'b0;
          acc_nxt   = 1'b1;
          if (cmd.known && cmd.query && cmd.empty) begin
            out_valid_nxt = 1'b1;
            out_cov_nxt   = 1'b0;
          end
        end
      end
      // Push pending assignments down both boundary paths
      ST_PUSH_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = p_node[NODE_W-1:1];
      end
      ST_PUSH_CHK: begin
        word_nxt = mem_rdata;
        if (mem_rdata[p_node[0]].pend) begin
          wdata[1]        = '{cov: mem_rdata[p_node[0]].cov, pend: 1'b1};
          wdata[0]        = '{cov: mem_rdata[p_node[0]].cov, pend: 1'b1};
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = p_node[POSITION_BITS-1:0];
          mem_req.wr_data = wdata;
        end else if (lvl_one) begin
          path_nxt = 1'b1;
          lvl_nxt  = LVL_W'(POSITION_BITS);
        end else begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end
      ST_PUSH_CLR: begin
        wdata                = word_r;
        wdata[p_node[0]].pend = 1'b0;
        mem_req.wr_en        = 1'b1;
        mem_req.wr_addr      = p_node[NODE_W-1:1];
        mem_req.wr_data      = wdata;
        if (lvl_one) begin
          path_nxt = 1'b1;
          lvl_nxt  = LVL_W'(POSITION_BITS);
        end else begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end
      // Climb from the leaves, taking the left boundary node when odd
      ST_LOOP_L: begin
        if (lo_r >= hi_r) begin
          if (query_r) begin
            out_valid_nxt = 1'b1;
            out_cov_nxt   = acc_r;
          end
          path_nxt = 1'b0;
          lvl_nxt  = LVL_W'(1);
        end else if (lo_r[0]) begin
          node_nxt = lo_r[NODE_W-1:0];
          lo_nxt   = lo_r + PTR_W'(1);
          side_nxt = 1'b0;
        end
      end
      // Take the right boundary node when odd
      ST_LOOP_R: begin
        if (hi_r[0]) begin
          hi_nxt   = hi_dec;
          node_nxt = hi_dec[NODE_W-1:0];
          side_nxt = 1'b1;
        end
      end
      ST_LOOP_SH: begin
        lo_nxt = lo_r >> 1;
        hi_nxt = hi_r >> 1;
      end
      ST_ND_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = node_r[NODE_W-1:1];
      end
      // Fold a covered flag into the answer or assign the node
      ST_ND_MOD: begin
        if (query_r) begin
          acc_nxt = acc_r & mem_rdata[node_r[0]].cov;
        end else begin
          wdata[node_r[0]] = '{cov: value_r, pend: 1'b1};
          mem_req.wr_en    = 1'b1;
          mem_req.wr_addr  = node_r[NODE_W-1:1];
          mem_req.wr_data  = wdata;
        end
      end
      // Rebuild ancestors bottom-up on both paths
      ST_RB_RDP: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = p_node[NODE_W-1:1];
      end
      ST_RB_RDC: begin
        word_nxt = mem_rdata;
        if (!mem_rdata[p_node[0]].pend) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = p_node[POSITION_BITS-1:0];
        end else if (lvl_top) begin
          path_nxt = 1'b1;
          lvl_nxt  = LVL_W'(1);
        end else begin
          lvl_nxt = lvl_r + LVL_W'(1);
        end
      end
      ST_RB_WR: begin
        wdata                = word_r;
        wdata[p_node[0]].cov = mem_rdata[0].cov & mem_rdata[1].cov;
        mem_req.wr_en        = 1'b1;
        mem_req.wr_addr      = p_node[NODE_W-1:1];
        mem_req.wr_data      = wdata;
        if (lvl_top) begin
          path_nxt = 1'b1;
          lvl_nxt  = LVL_W'(1);
        end else begin
          lvl_nxt = lvl_r + LVL_W'(1);
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    query_r   <= query_nxt;
    value_r   <= value_nxt;
    t0_r      <= t0_nxt;
    t1_r      <= t1_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    lvl_r     <= lvl_nxt;
    path_r    <= path_nxt;
    side_r    <= side_nxt;
    node_r    <= node_nxt;
    word_r    <= word_nxt;
    acc_r     <= acc_nxt;
    out_cov_r <= out_cov_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_cov   = out_cov_r;

endmodule

// ----- tb/range_coverage_tracker_unit_tb.sv -----
module range_coverage_tracker_unit_tb;
  import rct_pkg::*;

  localparam int SPAN = 1 << POSITION_BITS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1600;
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  // Expected query answers, oldest first; coverage map predicts them
  class coverage_scoreboard;
    bit covered_map [SPAN];
    bit answer_q [$];
    int n_errors;
    int n_checked;
    int n_ops [4];

    function void note_transaction(logic [OP_W-1:0] op, int unsigned s, int unsigned e);
      int unsigned cs;
      int unsigned ce;
      bit all_set;
      cs = (s > SPAN) ? SPAN : s;
      ce = (e > SPAN) ? SPAN : e;
      n_ops[op]++;
      if (op == OP_ADD || op == OP_REMOVE) begin
        for (int unsigned p = cs; p < ce; p++) covered_map[p] = (op == OP_ADD);
      end else if (op == OP_QUERY) begin
        all_set = (cs < ce);
        for (int unsigned p = cs; p < ce && all_set; p++)
          if (!covered_map[p]) all_set = 0;
        answer_q.push_back(all_set);
      end
    endfunction

    function void check_answer(logic fully_covered);
      bit exp_val;
      if (answer_q.size() == 0) begin
        $error("unexpected result: fully_covered=%0b", fully_covered);
        n_errors++;
        return;
      end
      exp_val = answer_q.pop_front();
      n_checked++;
      if (fully_covered !== exp_val) begin
        $error("fully_covered mismatch: expected %0b, actual %0b", exp_val, fully_covered);
        n_errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [OP_W-1:0] in_operation;
  logic [START_W-1:0] in_range_start;
  logic [END_W-1:0] in_range_end;
  logic out_valid;
  logic out_fully_covered;

  coverage_scoreboard sb;
  int idle_cycles = 0;

  range_coverage_tracker_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_range_start(in_range_start),
    .in_range_end(in_range_end), .out_valid(out_valid),
    .out_fully_covered(out_fully_covered)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Check each strobed result; count cycles with no transaction
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_answer(out_fully_covered);
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Stop the run if the block hangs
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("range_coverage_tracker_unit_tb: done, errors");
    $finish;
  end

  // Send one transaction after a random gap, hold until accepted;
  // start stays high afterwards until the next gap or a drain drops it
  task automatic send_item(logic [OP_W-1:0] op, int unsigned s, int unsigned e, bit gap);
    int unsigned wait_n;
    wait_n = gap ? $urandom_range(0, 15) : 0;
    if (wait_n != 0) begin
      start <= 0;
      repeat (wait_n) @(posedge clk);
    end
    start <= 1;
    in_operation <= op;
    in_range_start <= s[START_W-1:0];
    in_range_end <= e[END_W-1:0];
    do @(posedge clk); while (busy);
    sb.note_transaction(op, s[START_W-1:0], e[END_W-1:0]);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.answer_q.size() != 0) @(posedge clk);
  endtask

  // Mostly short ranges in two small windows at the ends of the domain so adds and queries interact
  task automatic random_item();
    logic [OP_W-1:0] op;
    int unsigned s;
    int unsigned e;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    op = (pick < 35) ? OP_ADD : (pick < 55) ? OP_REMOVE : (pick < 97) ? OP_QUERY : OP_UNKNOWN;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      s = $urandom_range(0, 255) + ($urandom_range(0, 1) ? 32'd65280 : 32'd0);
      e = s + $urandom_range(0, 48);
    end else if (pick < 80) begin
      s = $urandom_range(0, 65535);
      e = s - $urandom_range(0, 64);
    end else begin
      s = $urandom_range(0, 65535);
      e = $urandom_range(0, 131071);
    end
    send_item(op, s, e, $urandom_range(0, 3) != 0);
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    start = 0;
    in_operation = OP_ADD;
    in_range_start = '0;
    in_range_end = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes, every code, empty and clipped ranges
    send_item(OP_QUERY, 0, 65536, 0);
    send_item(OP_ADD, 0, 65536, 0);
    send_item(OP_QUERY, 0, 65536, 0);
    send_item(OP_QUERY, 65535, 65536, 0);
    send_item(OP_QUERY, 0, 131071, 0);
    send_item(OP_REMOVE, 100, 200, 1);
    send_item(OP_QUERY, 0, 100, 0);
    send_item(OP_QUERY, 99, 101, 0);
    send_item(OP_QUERY, 200, 201, 0);
    send_item(OP_QUERY, 5, 5, 0);
    send_item(OP_QUERY, 10, 3, 0);
    send_item(OP_REMOVE, 300, 300, 0);
    send_item(OP_UNKNOWN, 0, 65536, 0);
    send_item(OP_QUERY, 300, 301, 0);
    send_item(OP_REMOVE, 65535, 131071, 0);
    send_item(OP_QUERY, 65534, 65535, 0);
    send_item(OP_QUERY, 65535, 65536, 0);
    send_item(OP_ADD, 150, 151, 0);
    send_item(OP_QUERY, 150, 151, 0);
    send_item(OP_REMOVE, 0, 65536, 0);
    send_item(OP_QUERY, 150, 151, 0);
    send_item(OP_ADD, 65535, 65535, 0);
    send_item(OP_QUERY, 65535, 131071, 0);

    // Hold off until every answer is back
    drain();
    repeat (1200) @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      random_item();
      if (i == RANDOM_ITEMS / 2) drain();
    end

    drain();
    repeat (1200) @(posedge clk);
    $display("covered %0d adds, %0d removes, %0d queries, %0d unknown codes",
             sb.n_ops[OP_ADD], sb.n_ops[OP_REMOVE], sb.n_ops[OP_QUERY], sb.n_ops[OP_UNKNOWN]);
    $display("checked %0d query answers", sb.n_checked);
    if (sb.n_errors == 0 && sb.answer_q.size() == 0)
      $display("range_coverage_tracker_unit_tb: done, clean");
    else
      $display("range_coverage_tracker_unit_tb: done, errors");
    $finish;
  end

endmodule
